// ===== rtl/wvsdc_pkg.sv =====
// Shared types, constants and saturation helpers for the wave-variable drift control unit.
package wvsdc_pkg;

   // Ring history geometry
   localparam int HISTORY_DEPTH = 2048;
   localparam int AXES          = 3;
   localparam int RING_AW       = $clog2(HISTORY_DEPTH);
   localparam int AX_W          = 2;
   localparam int RING_WORDS    = AXES * HISTORY_DEPTH;
   localparam int RAM_AW        = $clog2(RING_WORDS);

   // Datapath widths
   localparam int DATA_W  = 32;
   localparam int GAIN_W  = 31;
   localparam int DELAY_W = 11;
   localparam int STATE_W = 48;
   localparam int T_W     = 51;        // widest internal sum or error
   localparam int P_W     = T_W + 32;  // full product width
   localparam int CSR_IDX_W = 4;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] REG_WAVE_GAIN       = 4'd0;
   localparam logic [CSR_IDX_W-1:0] REG_WAVE_GAIN_RECIP = 4'd1;
   localparam logic [CSR_IDX_W-1:0] REG_STIFFNESS       = 4'd2;
   localparam logic [CSR_IDX_W-1:0] REG_DAMPING         = 4'd3;
   localparam logic [CSR_IDX_W-1:0] REG_BLEND_RECIP     = 4'd4;
   localparam logic [CSR_IDX_W-1:0] REG_CORRECTION_GAIN = 4'd5;
   localparam logic [CSR_IDX_W-1:0] REG_STEP_TIME       = 4'd6;
   localparam logic [CSR_IDX_W-1:0] REG_DELAY_CYCLES    = 4'd7;

   // Multiplier shift and saturation selects
   typedef enum logic [1:0] {SH16, SH17, SH32} shift_type;
   typedef enum logic [1:0] {SAT32, SAT48, SAT49} satw_type;

   typedef struct packed {
      logic                   start;
      shift_type              sh;
      satw_type               w;
      logic signed [T_W-1:0]  a;
      logic [DATA_W-1:0]      b;
   } mul_req_type;

   typedef struct packed {
      logic busy;
      logic done;
   } mul_stat_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] wave_in_x;
      logic signed [DATA_W-1:0] wave_in_y;
      logic signed [DATA_W-1:0] wave_in_z;
      logic signed [DATA_W-1:0] velocity_x;
      logic signed [DATA_W-1:0] velocity_y;
      logic signed [DATA_W-1:0] velocity_z;
      logic signed [DATA_W-1:0] offset_x;
      logic signed [DATA_W-1:0] offset_y;
      logic signed [DATA_W-1:0] offset_z;
      logic signed [DATA_W-1:0] remote_pos_x;
      logic signed [DATA_W-1:0] remote_pos_y;
      logic signed [DATA_W-1:0] remote_pos_z;
   } req_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] force_x;
      logic signed [DATA_W-1:0] force_y;
      logic signed [DATA_W-1:0] force_z;
      logic signed [DATA_W-1:0] wave_out_x;
      logic signed [DATA_W-1:0] wave_out_y;
      logic signed [DATA_W-1:0] wave_out_z;
   } rsp_type;

   // Saturate a wide value to 48 bits
   function automatic logic signed [STATE_W-1:0] sat48(input logic signed [T_W-1:0] v);
      logic [T_W-STATE_W:0] top;
      top = v[T_W-1:STATE_W-1];
      if (top == '0 || top == '1) begin
         return v[STATE_W-1:0];
      end
      return v[T_W-1] ? {1'b1, {(STATE_W-1){1'b0}}} : {1'b0, {(STATE_W-1){1'b1}}};
   endfunction

   // Saturate a wide value to 32 bits
   function automatic logic signed [DATA_W-1:0] sat32(input logic signed [T_W-1:0] v);
      logic [T_W-DATA_W:0] top;
      top = v[T_W-1:DATA_W-1];
      if (top == '0 || top == '1) begin
         return v[DATA_W-1:0];
      end
      return v[T_W-1] ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
   endfunction

endpackage

// ===== rtl/wvsdc_ram.sv =====
// Generic simple dual-port RAM with registered read.
module wvsdc_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/wvsdc_mul.sv =====
// Shared multi-cycle multiply, round-half-away and saturate unit.
module wvsdc_mul (
   input  logic                         clock,
   input  logic                         reset,
   input  wvsdc_pkg::mul_req_type       req,
   output wvsdc_pkg::mul_stat_type      stat,
   output logic signed [wvsdc_pkg::T_W-1:0] result
);
   import wvsdc_pkg::*;

   typedef enum logic [1:0] {M_IDLE, M_LO, M_HI, M_FIN} mst_type;

   mst_type             st_ff;
   logic                done_ff;
   logic [T_W-1:0]      mag_ff;
   logic                neg_ff;
   logic [DATA_W-1:0]   b_ff;
   shift_type           sh_ff;
   satw_type            w_ff;
   logic [63:0]         plo_ff;
   logic [T_W-1:0]      phi_ff;
   logic signed [T_W-1:0] res_ff;

   logic [P_W-1:0]      prod, rnd, lim, r, mag_res;
   logic [5:0]          shamt;
   logic signed [T_W-1:0] res_in;

   // Combine partial products, round, shift and saturate the magnitude
   always_comb begin
      prod = (P_W'(phi_ff) << 32) + P_W'(plo_ff);
      case (sh_ff)
         SH16:    shamt = 6'd16;
         SH17:    shamt = 6'd17;
         SH32:    shamt = 6'd32;
         default: shamt = 6'd32;
      endcase
      rnd = P_W'(1) << (shamt - 6'd1);
      r   = (prod + rnd) >> shamt;
      case (w_ff)
         SAT32:   lim = P_W'(1) << 31;
         SAT48:   lim = P_W'(1) << 47;
         SAT49:   lim = P_W'(1) << 48;
         default: lim = P_W'(1) << 31;
      endcase
      if (r >= lim) begin
         mag_res = neg_ff ? lim : lim - P_W'(1);
      end else begin
         mag_res = r;
      end
      res_in = neg_ff ? -T_W'(mag_res) : T_W'(mag_res);
   end

   // Sequencer: latch, low half product, high half product, finish
   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff   <= M_IDLE;
         done_ff <= 1'b0;
      end else begin
         done_ff <= (st_ff == M_FIN);
         case (st_ff)
            M_IDLE: begin
               if (req.start) begin
                  mag_ff <= req.a[T_W-1] ? T_W'(-req.a) : T_W'(req.a);
                  neg_ff <= req.a[T_W-1];
                  b_ff   <= req.b;
                  sh_ff  <= req.sh;
                  w_ff   <= req.w;
                  st_ff  <= M_LO;
               end
            end
            M_LO: begin
               plo_ff <= 64'(mag_ff[31:0]) * 64'(b_ff);
               st_ff  <= M_HI;
            end
            M_HI: begin
               phi_ff <= T_W'(mag_ff[T_W-1:32]) * T_W'(b_ff);
               st_ff  <= M_FIN;
            end
            M_FIN: begin
               res_ff  <= res_in;
               st_ff   <= M_IDLE;
            end
            default: st_ff <= M_IDLE;
         endcase
      end
   end

   assign stat.busy = (st_ff != M_IDLE);
   assign stat.done = done_ff;
   assign result    = res_ff;

endmodule

// ===== rtl/wave_variable_slave_drift_control_unit.sv =====
// Top level: wave-variable slave controller with drift correction, three axes.
//
//  channel | ports                          | direction | payload
//  req     | req_valid, req_ready, req_data | in        | waves, velocity, offset, remote pos
//  rsp     | rsp_valid, rsp_ready, rsp_data | out       | force and corrected wave
//  csr     | csr_wr_en, csr_index, csr_wr_data | in     | eight gain/timing registers
//
// Each item runs eleven products per axis on the shared multiplier, plus one RAM read
// and one product for each history entry, n entries per axis, n being the delay change
// in ticks (1 when unchanged).
// After reset all 6144 history RAM words are cleared, with req_ready low.
// The result sits in an output register; the next item is accepted once it is loaded.
module wave_variable_slave_drift_control_unit (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  wvsdc_pkg::req_type                 req_data,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output wvsdc_pkg::rsp_type                 rsp_data,
   input  logic                               csr_wr_en,
   input  logic [wvsdc_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [wvsdc_pkg::DATA_W-1:0]       csr_wr_data
);
   import wvsdc_pkg::*;

   typedef enum logic [3:0] {
      S_CLEAR, S_IDLE, S_DP, S_N1, S_N2, S_N3, S_DV, S_F1, S_F2,
      S_WO, S_PRED, S_CORR, S_RD, S_RING, S_WS, S_OUT
   } st_type;

   // Configuration registers
   logic [GAIN_W-1:0]  wave_gain_ff, wave_gain_recip_ff, stiffness_ff, damping_ff;
   logic [GAIN_W-1:0]  blend_recip_ff, correction_gain_ff;
   logic [DATA_W-1:0]  step_time_ff;
   logic [DELAY_W-1:0] delay_cycles_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         wave_gain_ff       <= GAIN_W'(293085);
         wave_gain_recip_ff <= GAIN_W'(29309);
         stiffness_ff       <= GAIN_W'(65536000);
         damping_ff         <= GAIN_W'(4144959);
         blend_recip_ff     <= GAIN_W'(895);
         correction_gain_ff <= GAIN_W'(18415118);
         step_time_ff       <= DATA_W'(4294967);
         delay_cycles_ff    <= DELAY_W'(1);
      end else if (csr_wr_en) begin
         case (csr_index)
            REG_WAVE_GAIN:       wave_gain_ff       <= csr_wr_data[GAIN_W-1:0];
            REG_WAVE_GAIN_RECIP: wave_gain_recip_ff <= csr_wr_data[GAIN_W-1:0];
            REG_STIFFNESS:       stiffness_ff       <= csr_wr_data[GAIN_W-1:0];
            REG_DAMPING:         damping_ff         <= csr_wr_data[GAIN_W-1:0];
            REG_BLEND_RECIP:     blend_recip_ff     <= csr_wr_data[GAIN_W-1:0];
            REG_CORRECTION_GAIN: correction_gain_ff <= csr_wr_data[GAIN_W-1:0];
            REG_STEP_TIME:       step_time_ff       <= csr_wr_data;
            REG_DELAY_CYCLES:    delay_cycles_ff    <= csr_wr_data[DELAY_W-1:0];
            default: ;
         endcase
      end
   end

   // Sequencer state and datapath registers
   st_type                 st_ff;
   logic                   issued_ff;
   logic [AX_W-1:0]        ax_ff;
   logic [RAM_AW-1:0]      clr_addr_ff;
   req_type                req_ff;
   rsp_type                res_ff, rsp_data_ff;
   logic                   rsp_valid_ff;
   logic signed [STATE_W-1:0] dp_ff [AXES];
   logic signed [DATA_W-1:0]  dv_ff [AXES];
   logic signed [STATE_W-1:0] ws_ff [AXES];
   logic [RING_AW-1:0]     ptr_ff, raddr_ff, idx_ff;
   logic [DELAY_W-1:0]     prev_delay_ff, cur_ff, n_ff, cnt_ff;
   logic                   up_ff;
   logic signed [T_W-1:0]  err_ff, num_ff, fsum_ff, wo_ff, diff_ff, wsacc_ff;
   logic signed [DATA_W-1:0] wo32_ff;

   // Multiplier and RAM hookup
   mul_req_type            mul_req;
   mul_stat_type           mul_stat;
   logic signed [T_W-1:0]  m;
   logic                   ram_wr_en, ram_rd_en;
   logic [RAM_AW-1:0]      ram_wr_addr, ram_rd_addr;
   logic [DATA_W-1:0]      ram_wr_data, ram_rd_data;

   wvsdc_mul u_mul (
      .clock  (clock),
      .reset  (reset),
      .req    (mul_req),
      .stat   (mul_stat),
      .result (m)
   );

   wvsdc_ram #(.WIDTH(DATA_W), .DEPTH(RING_WORDS)) u_ring (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // Per-axis field select
   logic signed [DATA_W-1:0] win, vel, off, rem;
   always_comb begin
      case (ax_ff)
         2'd0: begin
            win = req_ff.wave_in_x; vel = req_ff.velocity_x;
            off = req_ff.offset_x;  rem = req_ff.remote_pos_x;
         end
         2'd1: begin
            win = req_ff.wave_in_y; vel = req_ff.velocity_y;
            off = req_ff.offset_y;  rem = req_ff.remote_pos_y;
         end
         2'd2: begin
            win = req_ff.wave_in_z; vel = req_ff.velocity_z;
            off = req_ff.offset_z;  rem = req_ff.remote_pos_z;
         end
         default: begin
            win = '0; vel = '0; off = '0; rem = '0;
         end
      endcase
   end

   // Operand select for the shared multiplier
   logic is_step;
   always_comb begin
      is_step   = 1'b1;
      mul_req.a = '0;
      mul_req.b = step_time_ff;
      mul_req.sh = SH16;
      mul_req.w  = SAT48;
      case (st_ff)
         S_DP: begin
            mul_req.a = T_W'(dv_ff[ax_ff]); mul_req.sh = SH32;
         end
         S_N1:   begin mul_req.a = T_W'(win);     mul_req.b = DATA_W'(wave_gain_ff); end
         S_N2:   begin mul_req.a = T_W'(vel);     mul_req.b = DATA_W'(damping_ff);   end
         S_N3:   begin mul_req.a = err_ff;        mul_req.b = DATA_W'(stiffness_ff); end
         S_DV: begin
            mul_req.a = num_ff; mul_req.b = DATA_W'(blend_recip_ff); mul_req.w = SAT32;
         end
         S_F1:   begin mul_req.a = -err_ff;       mul_req.b = DATA_W'(stiffness_ff); end
         S_F2: begin
            mul_req.a = T_W'(dv_ff[ax_ff]) - T_W'(vel);
            mul_req.b = DATA_W'(damping_ff);
         end
         S_WO:   begin mul_req.a = fsum_ff; mul_req.b = DATA_W'(wave_gain_recip_ff); end
         S_PRED: begin
            mul_req.a = T_W'(ws_ff[ax_ff]); mul_req.b = DATA_W'(wave_gain_recip_ff);
            mul_req.sh = SH17;
         end
         S_CORR: begin
            mul_req.a = diff_ff; mul_req.b = DATA_W'(correction_gain_ff); mul_req.w = SAT49;
         end
         S_RING: begin
            mul_req.a = T_W'(signed'(ram_rd_data)); mul_req.sh = SH32;
         end
         S_WS:   begin mul_req.a = T_W'(wo32_ff); mul_req.sh = SH32; end
         default: is_step = 1'b0;
      endcase
      mul_req.start = is_step && !issued_ff;
   end

   logic step_done;
   assign step_done = is_step && issued_ff && mul_stat.done;

   // Desired position update, error and drift correction terms
   logic signed [STATE_W-1:0] dp_new;
   logic signed [T_W-1:0]     abs_c, abs_w, wo_c;
   logic                      flip;
   always_comb begin
      dp_new = sat48(T_W'(dp_ff[ax_ff]) + m);
      flip   = (diff_ff == '0) || (wo_ff == '0) || (diff_ff[T_W-1] != wo_ff[T_W-1]);
      abs_c  = m[T_W-1] ? -m : m;
      abs_w  = wo_ff[T_W-1] ? -wo_ff : wo_ff;
      if (flip) begin
         wo_c = (abs_c < abs_w) ? wo_ff + m : '0;
      end else begin
         wo_c = wo_ff;
      end
   end

   // Ring RAM ports: clearing pass, per-axis history reads and the new entry
   always_comb begin
      ram_wr_en   = (st_ff == S_CLEAR) || (st_ff == S_WS && step_done);
      ram_wr_addr = (st_ff == S_CLEAR) ? clr_addr_ff
                                       : (RAM_AW'(ax_ff) << RING_AW) | RAM_AW'(ptr_ff);
      ram_wr_data = (st_ff == S_CLEAR) ? '0 : wo32_ff;
      ram_rd_en   = (st_ff == S_RD);
      ram_rd_addr = (RAM_AW'(ax_ff) << RING_AW) | RAM_AW'(raddr_ff);
   end

   // Main sequencer; delay register is 11 bits, so it never reaches the depth
   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff         <= S_CLEAR;
         issued_ff     <= 1'b0;
         clr_addr_ff   <= '0;
         ax_ff         <= '0;
         rsp_valid_ff  <= 1'b0;
         ptr_ff        <= '0;
         prev_delay_ff <= DELAY_W'(3);
         for (int i = 0; i < AXES; i++) begin
            dp_ff[i] <= '0;
            dv_ff[i] <= '0;
            ws_ff[i] <= '0;
         end
      end else begin
         if (rsp_valid_ff && rsp_ready && st_ff != S_OUT) begin
            rsp_valid_ff <= 1'b0;
         end
         if (mul_req.start) begin
            issued_ff <= 1'b1;
         end
         if (step_done) begin
            issued_ff <= 1'b0;
         end
         case (st_ff)
            S_CLEAR: begin
               clr_addr_ff <= clr_addr_ff + RAM_AW'(1);
               if (clr_addr_ff == RAM_AW'(RING_WORDS - 1)) begin
                  st_ff <= S_IDLE;
               end
            end
            S_IDLE: begin
               if (req_valid) begin
                  req_ff <= req_data;
                  res_ff <= '0;
                  ax_ff  <= '0;
                  cur_ff <= delay_cycles_ff;
                  idx_ff <= ptr_ff - RING_AW'(delay_cycles_ff);
                  up_ff  <= delay_cycles_ff > prev_delay_ff;
                  if (delay_cycles_ff == prev_delay_ff) begin
                     n_ff <= DELAY_W'(1);
                  end else if (delay_cycles_ff > prev_delay_ff) begin
                     n_ff <= delay_cycles_ff - prev_delay_ff;
                  end else begin
                     n_ff <= prev_delay_ff - delay_cycles_ff;
                  end
                  st_ff <= S_DP;
               end
            end
            S_DP: if (step_done) begin
               dp_ff[ax_ff] <= dp_new;
               err_ff <= T_W'(off) - T_W'(dp_new);
               st_ff  <= S_N1;
            end
            S_N1: if (step_done) begin num_ff <= m;          st_ff <= S_N2; end
            S_N2: if (step_done) begin num_ff <= num_ff + m; st_ff <= S_N3; end
            S_N3: if (step_done) begin num_ff <= num_ff + m; st_ff <= S_DV; end
            S_DV: if (step_done) begin
               dv_ff[ax_ff] <= m[DATA_W-1:0];
               st_ff <= S_F1;
            end
            S_F1: if (step_done) begin fsum_ff <= m;           st_ff <= S_F2; end
            S_F2: if (step_done) begin fsum_ff <= fsum_ff + m; st_ff <= S_WO; end
            S_WO: if (step_done) begin
               wo_ff <= T_W'(win) - m;
               st_ff <= S_PRED;
            end
            S_PRED: if (step_done) begin
               diff_ff <= -m - (T_W'(rem) - T_W'(dp_ff[ax_ff]));
               st_ff   <= S_CORR;
            end
            S_CORR: if (step_done) begin
               wo32_ff  <= sat32(wo_c);
               wsacc_ff <= T_W'(ws_ff[ax_ff]);
               raddr_ff <= up_ff ? idx_ff + RING_AW'(1) : idx_ff;
               cnt_ff   <= n_ff;
               case (ax_ff)
                  2'd0: begin
                     res_ff.force_x <= sat32(fsum_ff); res_ff.wave_out_x <= sat32(wo_c);
                  end
                  2'd1: begin
                     res_ff.force_y <= sat32(fsum_ff); res_ff.wave_out_y <= sat32(wo_c);
                  end
                  2'd2: begin
                     res_ff.force_z <= sat32(fsum_ff); res_ff.wave_out_z <= sat32(wo_c);
                  end
                  default: ;
               endcase
               st_ff <= S_RD;
            end
            S_RD: st_ff <= S_RING;
            // Delayed history entries: added when the delay grew, else subtracted
            S_RING: if (step_done) begin
               wsacc_ff <= up_ff ? wsacc_ff + m : wsacc_ff - m;
               raddr_ff <= up_ff ? raddr_ff + RING_AW'(1) : raddr_ff - RING_AW'(1);
               cnt_ff   <= cnt_ff - DELAY_W'(1);
               st_ff    <= (cnt_ff == DELAY_W'(1)) ? S_WS : S_RD;
            end
            S_WS: if (step_done) begin
               ws_ff[ax_ff] <= sat48(wsacc_ff + m);
               if (ax_ff == AX_W'(AXES - 1)) begin
                  st_ff <= S_OUT;
               end else begin
                  ax_ff <= ax_ff + AX_W'(1);
                  st_ff <= S_DP;
               end
            end
            S_OUT: begin
               if (!rsp_valid_ff || rsp_ready) begin
                  rsp_data_ff   <= res_ff;
                  rsp_valid_ff  <= 1'b1;
                  prev_delay_ff <= cur_ff;
                  ptr_ff        <= ptr_ff + RING_AW'(1);
                  st_ff         <= S_IDLE;
               end
            end
            default: st_ff <= S_IDLE;
         endcase
      end
   end

   assign req_ready = (st_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Checks
   a_mul_free: assert property (@(posedge clock) disable iff (reset)
      mul_req.start |-> !mul_stat.busy)
      else $error("multiplier started while busy");

   a_one_item: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("second item taken while one is in flight");

   a_rsp_src: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(st_ff == S_OUT))
      else $error("result raised outside output load");

endmodule

// ===== dv/testbench.sv =====
// Self-checking testbench for the wave-variable slave drift control unit.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import wvsdc_pkg::*;

   localparam int DEPTH      = HISTORY_DEPTH;
   localparam int WDOG_LIMIT = 200000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   req_type req_data = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   rsp_type rsp_data;
   logic csr_wr_en = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [DATA_W-1:0] csr_wr_data = '0;

   // Model registers and state
   logic [30:0] m_gain, m_gain_recip, m_stiff, m_damp, m_blend, m_corr;
   logic [31:0] m_step;
   logic [10:0] m_delay;
   longint dpos [3];
   longint dvel [3];
   longint wsum [3];
   longint hist [3][DEPTH];
   int unsigned hist_ptr;
   int unsigned last_delay;

   rsp_type expected_q[$];
   int errors = 0;
   bit no_idle = 1'b0;
   bit hold_request = 1'b0;

   typedef struct {
      req_type d;
      bit      typed;
      rsp_type r;
   } dir_row_type;
   dir_row_type dir_tab[10];

   wave_variable_slave_drift_control_unit u_dut (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Exact product, shift with rounding half away from zero, then saturate to w bits
   function automatic longint round_mul(longint a, logic [31:0] b, int sh, int w);
      logic [127:0] p;
      logic [127:0] lim;
      longint unsigned mag;
      bit neg;
      neg = a < 0;
      mag = neg ? -a : a;
      p = {64'd0, mag} * {96'd0, b};
      p = (p + (128'd1 << (sh - 1))) >> sh;
      lim = 128'd1 << (w - 1);
      if (p >= lim) return neg ? -(longint'(1) << (w - 1)) : (longint'(1) << (w - 1)) - 1;
      return neg ? -longint'(p[63:0]) : longint'(p[63:0]);
   endfunction

   function automatic longint clip(longint v, int w);
      longint lim;
      lim = longint'(1) << (w - 1);
      if (v >= lim) return lim - 1;
      if (v < -lim) return -lim;
      return v;
   endfunction

   // One control tick of the predictor
   function automatic rsp_type control_tick(req_type d);
      longint win [3];
      longint vel [3];
      longint off [3];
      longint rem [3];
      longint frc [3];
      longint wvo [3];
      longint err, num, fsum, wo, pred, diff, corr, ws, ad, aw;
      int unsigned cur, idx;
      int ddiff;
      rsp_type r;
      win = '{d.wave_in_x, d.wave_in_y, d.wave_in_z};
      vel = '{d.velocity_x, d.velocity_y, d.velocity_z};
      off = '{d.offset_x, d.offset_y, d.offset_z};
      rem = '{d.remote_pos_x, d.remote_pos_y, d.remote_pos_z};
      cur = (m_delay >= DEPTH) ? DEPTH - 1 : m_delay;
      idx = (hist_ptr + DEPTH - cur) % DEPTH;
      ddiff = int'(cur) - int'(last_delay);
      for (int a = 0; a < 3; a++) begin
         dpos[a] = clip(dpos[a] + round_mul(dvel[a], m_step, 32, 48), 48);
         err = off[a] - dpos[a];
         num = round_mul(win[a], {1'b0, m_gain}, 16, 48) +
               round_mul(vel[a], {1'b0, m_damp}, 16, 48) +
               round_mul(err, {1'b0, m_stiff}, 16, 48);
         dvel[a] = round_mul(num, {1'b0, m_blend}, 16, 32);
         fsum = round_mul(-err, {1'b0, m_stiff}, 16, 48) +
                round_mul(dvel[a] - vel[a], {1'b0, m_damp}, 16, 48);
         wo = win[a] - round_mul(fsum, {1'b0, m_gain_recip}, 16, 48);
         // drift correction, applied when the signs disagree or either is zero
         pred = -round_mul(wsum[a], {1'b0, m_gain_recip}, 17, 48);
         diff = pred - (rem[a] - dpos[a]);
         corr = round_mul(diff, {1'b0, m_corr}, 16, 49);
         if (diff == 0 || wo == 0 || ((diff < 0) != (wo < 0))) begin
            ad = corr < 0 ? -corr : corr;
            aw = wo < 0 ? -wo : wo;
            if (ad < aw) wo = wo + corr;
            else wo = 0;
         end
         wvo[a] = clip(wo, 32);
         frc[a] = clip(fsum, 32);
         // wave integral follows the delayed history
         ws = wsum[a];
         if (ddiff == 0) begin
            ws -= round_mul(hist[a][idx], m_step, 32, 48);
         end else if (ddiff > 0) begin
            for (int j = 1; j <= ddiff; j++)
               ws += round_mul(hist[a][(idx + j) % DEPTH], m_step, 32, 48);
         end else begin
            for (int j = 0; j < -ddiff; j++)
               ws -= round_mul(hist[a][(idx + DEPTH - j) % DEPTH], m_step, 32, 48);
         end
         ws += round_mul(wvo[a], m_step, 32, 48);
         wsum[a] = clip(ws, 48);
         hist[a][hist_ptr] = wvo[a];
      end
      last_delay = cur;
      hist_ptr = (hist_ptr + 1) % DEPTH;
      r.force_x = frc[0][31:0];
      r.force_y = frc[1][31:0];
      r.force_z = frc[2][31:0];
      r.wave_out_x = wvo[0][31:0];
      r.wave_out_y = wvo[1][31:0];
      r.wave_out_z = wvo[2][31:0];
      return r;
   endfunction

   task automatic note_error(string msg);
      errors++;
      if (errors <= 10) $display("ERROR %0t: %s", $realtime, msg);
   endtask

   // Item field: extremes, full range or small magnitudes
   function automatic logic [31:0] rand_word();
      int s;
      case ($urandom_range(0, 9))
         0: return 32'h8000_0000;
         1: return 32'h7fff_ffff;
         2: return 32'hffff_ffff;
         3, 4, 5: return $urandom;
         default: begin
            s = $urandom_range(0, 1 << 20);
            return $urandom_range(0, 1) ? -s : s;
         end
      endcase
   endfunction

   function automatic req_type rand_item();
      req_type d;
      for (int k = 0; k < 12; k++) d[383 - 32*k -: 32] = rand_word();
      return d;
   endfunction

   // Send one item and record its expected result on acceptance
   task automatic send_item(req_type d, bit typed, rsp_type r);
      rsp_type p;
      if (!no_idle && $urandom_range(0, 99) < 22) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= d;
      do @(posedge clock); while (!req_ready);
      p = control_tick(d);
      expected_q.push_back(typed ? r : p);
   endtask

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [31:0] v);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wr_data <= v;
      @(posedge clock);
      case (idx)
         REG_WAVE_GAIN:       m_gain = v[30:0];
         REG_WAVE_GAIN_RECIP: m_gain_recip = v[30:0];
         REG_STIFFNESS:       m_stiff = v[30:0];
         REG_DAMPING:         m_damp = v[30:0];
         REG_BLEND_RECIP:     m_blend = v[30:0];
         REG_CORRECTION_GAIN: m_corr = v[30:0];
         REG_STEP_TIME:       m_step = v;
         REG_DELAY_CYCLES:    m_delay = v[10:0];
         default: ;
      endcase
   endtask

   // Drain the block, then load a full register set plus an unmapped index
   task automatic load_settings(logic [31:0] v[8]);
      req_valid <= 1'b0;
      while (expected_q.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      for (int i = 0; i < 8; i++) write_reg(CSR_IDX_W'(i), v[i]);
      write_reg(CSR_IDX_W'($urandom_range(8, 15)), $urandom);
      csr_wr_en <= 1'b0;
      @(posedge clock);
   endtask

   function automatic logic [31:0] near(logic [31:0] dflt);
      if ($urandom_range(0, 3) == 0) return $urandom & 32'h7fff_ffff;
      return $urandom_range(0, 2 * dflt);
   endfunction

   // Stimulus
   initial begin
      logic [31:0] cfg[8];
      rsp_type zero_rsp;
      zero_rsp = '0;
      m_gain = 31'd293085;
      m_gain_recip = 31'd29309;
      m_stiff = 31'd65536000;
      m_damp = 31'd4144959;
      m_blend = 31'd895;
      m_corr = 31'd18415118;
      m_step = 32'd4294967;
      m_delay = 11'd1;
      for (int a = 0; a < 3; a++) begin
         dpos[a] = 0;
         dvel[a] = 0;
         wsum[a] = 0;
         for (int i = 0; i < DEPTH; i++) hist[a][i] = 0;
      end
      hist_ptr = 0;
      last_delay = 3;

      // directed rows: only the first is known outright (all zero after reset)
      foreach (dir_tab[i]) begin
         dir_tab[i].typed = 1'b0;
         dir_tab[i].r = '0;
      end
      dir_tab[0].d = '0;
      dir_tab[0].typed = 1'b1;
      dir_tab[0].r = zero_rsp;
      dir_tab[1].d = {12{32'h7fff_ffff}};
      dir_tab[2].d = {12{32'h8000_0000}};
      dir_tab[3].d = {12{32'hffff_ffff}};
      dir_tab[4].d = {{3{32'h7fff_ffff}}, {3{32'h8000_0000}}, {3{32'h7fff_ffff}},
                      {3{32'h8000_0000}}};
      dir_tab[5].d = {{3{32'h0001_0000}}, {3{32'd0}}, {3{32'hffff_0000}}, {3{32'd0}}};
      dir_tab[6].d = {{3{32'd0}}, {3{32'd0}}, {3{32'd0}}, {3{32'h7fff_ffff}}};
      dir_tab[7].d = {{3{32'd0}}, {3{32'd0}}, {3{32'd0}}, {3{32'h8000_0000}}};
      dir_tab[8].d = {{3{32'h0000_8000}}, {3{32'h0002_0000}}, {3{32'h0000_0001}},
                      {3{32'hfffe_0000}}};
      dir_tab[9].d = '0;

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      foreach (dir_tab[i]) send_item(dir_tab[i].d, dir_tab[i].typed, dir_tab[i].r);

      for (int ph = 0; ph < 9; ph++) begin
         case (ph)
            0: ;
            1: cfg = '{32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
                       32'h7fff_ffff, 32'h7fff_ffff, 32'hffff_ffff, 32'd2047};
            2: cfg = '{0, 0, 0, 0, 0, 0, 0, 0};
            default: begin
               cfg[0] = near(293085);
               cfg[1] = near(29309);
               cfg[2] = near(65536000);
               cfg[3] = near(4144959);
               cfg[4] = near(895);
               cfg[5] = near(18415118);
               cfg[6] = $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 1 << 24);
               cfg[7] = $urandom_range(0, 40);
            end
         endcase
         if (ph != 0) load_settings(cfg);
         for (int i = 0; i < (ph == 0 ? 300 : 116); i++) begin
            if (ph == 0 && i == 80) hold_request = 1'b1;
            no_idle = (ph == 0 && i >= 150 && i < 260);
            send_item(rand_item(), 1'b0, zero_rsp);
         end
      end
      req_valid <= 1'b0;
      while (expected_q.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      if (errors == 0) $display("TEST PASSED");
      else $display("TEST FAILED");
      $finish;
   end

   // Result side: random ready, one long hold-off, field-by-field check
   string field_name[6] = '{"force_x", "force_y", "force_z",
                            "wave_out_x", "wave_out_y", "wave_out_z"};
   initial begin
      rsp_type exp_rsp;
      int hold_cnt;
      hold_cnt = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && rsp_ready) begin
            if (expected_q.size() == 0) begin
               note_error("result with nothing expected");
            end else begin
               exp_rsp = expected_q.pop_front();
               for (int k = 0; k < 6; k++)
                  if (rsp_data[191 - 32*k -: 32] !== exp_rsp[191 - 32*k -: 32])
                     note_error($sformatf("%s expected %h got %h", field_name[k],
                                          exp_rsp[191 - 32*k -: 32],
                                          rsp_data[191 - 32*k -: 32]));
            end
         end
         if (hold_request && hold_cnt == 0) begin
            hold_cnt = 600;
            hold_request = 1'b0;
         end
         if (hold_cnt > 0) hold_cnt--;
         rsp_ready <= (hold_cnt > 0) ? 1'b0 :
                      (no_idle ? 1'b1 : ($urandom_range(0, 99) >= 22));
      end
   end

   // Watchdog on cycles with no item moving on either side
   initial begin
      int quiet;
      quiet = 0;
      forever begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet = 0;
         else quiet++;
         if (quiet >= WDOG_LIMIT) begin
            $display("TEST FAILED");
            $finish;
         end
      end
   end

   // Leftover expectations are caught by the drain loop above, which would stall
   // into the watchdog if a result never came.
endmodule
